// ===== rtl/core/ewq_pkg.sv =====
// Shared types and constants for the extrusion wall quad generator.
// No dependencies; imported by ewq_normal_unit and the top level.
`timescale 1ns / 1ps
`default_nettype none
package ewq_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_HALF_DEPTH   = 2'd0;
	localparam logic [1:0] REG_START_VERTEX = 2'd1;
	localparam logic [1:0] REG_WALLS_ENABLE = 2'd2;

	localparam logic REC_VERTEX = 1'b0;
	localparam logic REC_INDEX  = 1'b1;

	// the larger normalized magnitude lies in [2^NORM_LO, 2^(NORM_LO+1))
	localparam int NORM_LO = 24;
	localparam int NORM_W  = NORM_LO + 1;
	localparam int RECS_PER_QUAD = 10;

	typedef enum logic [1:0] {
		S_IDLE,
		S_NORM,
		S_EMIT
	} ctl_state_t;

	typedef enum logic [2:0] {
		N_IDLE,
		N_SHIFT,
		N_SQ1,
		N_SQ2,
		N_SQRT,
		N_LOAD,
		N_DIV1,
		N_DIV2
	} norm_state_t;

	// index record offsets: s, s+1, s+2, s, s+2, s+3
	function automatic logic [1:0] idx_offset(input logic [3:0] rec);
		unique case (rec)
			4'd5: idx_offset = 2'd1;
			4'd6: idx_offset = 2'd2;
			4'd8: idx_offset = 2'd2;
			4'd9: idx_offset = 2'd3;
			default: idx_offset = 2'd0;
		endcase
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ewq_normal_unit.sv =====
// Iterative edge normal unit: normalizing shift, two squares, bit-pair square
// root and two restoring divisions over one shared compare-subtract unit. Uses ewq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ewq_normal_unit #(
	parameter int COORD_WIDTH  = 24,
	parameter int NORMAL_WIDTH = 16
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	input  wire signed [COORD_WIDTH-1:0]  ax,
	input  wire signed [COORD_WIDTH-1:0]  ay,
	input  wire signed [COORD_WIDTH-1:0]  bx,
	input  wire signed [COORD_WIDTH-1:0]  by,
	output logic                          done,
	output logic [NORMAL_WIDTH-1:0]       nx,
	output logic [NORMAL_WIDTH-1:0]       ny
);
	import ewq_pkg::*;

	localparam int DW   = COORD_WIDTH + 1;
	localparam int MAGW = (DW > NORM_W) ? DW : NORM_W;
	localparam int QB   = NORMAL_WIDTH + 2;
	localparam int NUMW = NORM_W + NORMAL_WIDTH + 5;
	localparam int DIVW = NUMW + 1;
	localparam logic [QB-1:0] MAXPOS = QB'((1 << (NORMAL_WIDTH - 1)) - 1);

	norm_state_t state_q, state_d;
	logic [MAGW-1:0] mx_q, my_q;
	logic            dy_neg_q, dx_pos_q;
	logic [49:0]     acc_q;
	logic [63:0]     x_q, r_q, bit_q;
	logic [31:0]     len_q, rem_q;
	logic [QB-1:0]   dsh_q;
	logic [4:0]      cnt_q;

	logic signed [DW-1:0] dx, dy;
	logic [DW-1:0]   adx, ady;
	logic [MAGW-1:0] big;
	logic            too_big, too_small;
	logic [63:0]     opa, opb;
	logic [64:0]     diff;
	logic            ge;
	logic [24:0]     sq_in;
	logic [49:0]     sq;
	logic            last_iter;

	assign dx  = DW'(bx) - DW'(ax);
	assign dy  = DW'(by) - DW'(ay);
	assign adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
	assign ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
	assign big = (mx_q > my_q) ? mx_q : my_q;
	assign too_big   = (big >> NORM_W) != '0;
	assign too_small = !big[NORM_LO];

	assign sq_in = (state_q == N_SQ1) ? mx_q[NORM_W-1:0] : my_q[NORM_W-1:0];
	assign sq    = sq_in * sq_in;

	// shared compare-subtract
	always_comb begin
		if (state_q == N_SQRT) begin
			opa = x_q;
			opb = r_q | bit_q;
		end else begin
			opa = {31'b0, rem_q, dsh_q[QB-1]};
			opb = {32'b0, len_q};
		end
		diff = {1'b0, opa} - {1'b0, opb};
		ge   = !diff[64];
	end

	assign last_iter = (cnt_q == 5'd0);

	function automatic logic [NORMAL_WIDTH-1:0] sat(input logic [QB-1:0] q, input logic neg);
		logic [QB-1:0] v;
		begin
			if (neg) begin
				v = (q > MAXPOS + QB'(1)) ? MAXPOS + QB'(1) : q;
				v = QB'(0) - v;
			end else begin
				v = (q > MAXPOS) ? MAXPOS : q;
			end
			sat = v[NORMAL_WIDTH-1:0];
		end
	endfunction

	function automatic logic [DIVW-1:0] dividend(input logic [NORM_W-1:0] m,
			input logic [31:0] l);
		dividend = DIVW'({m, 5'b0, NORMAL_WIDTH'(0)}) + DIVW'(l[31:1]);
	endfunction

	function automatic logic [DIVW-QB-1:0] dvd_next_hi(input logic [NORM_W-1:0] m,
			input logic [31:0] l);
		logic [DIVW-1:0] d;
		begin
			d = dividend(m, l);
			dvd_next_hi = d[DIVW-1:QB];
		end
	endfunction

	function automatic logic [QB-1:0] dvd_next_lo(input logic [NORM_W-1:0] m,
			input logic [31:0] l);
		logic [DIVW-1:0] d;
		begin
			d = dividend(m, l);
			dvd_next_lo = d[QB-1:0];
		end
	endfunction

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			N_IDLE:  if (start) state_d = N_SHIFT;
			N_SHIFT: if (!too_big && !too_small) state_d = N_SQ1;
			N_SQ1:   state_d = N_SQ2;
			N_SQ2:   state_d = N_SQRT;
			N_SQRT:  if (last_iter) state_d = N_LOAD;
			N_LOAD:  state_d = N_DIV1;
			N_DIV1:  if (last_iter) state_d = N_DIV2;
			N_DIV2:  if (last_iter) state_d = N_IDLE;
			default: state_d = N_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= (state_q == N_DIV2) && last_iter;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			N_IDLE: begin
				mx_q     <= MAGW'(adx);
				my_q     <= MAGW'(ady);
				dy_neg_q <= dy[DW-1];
				dx_pos_q <= !dx[DW-1] && (dx != '0);
			end
			N_SHIFT: begin
				if (too_big) begin
					mx_q <= mx_q >> 1;
					my_q <= my_q >> 1;
				end else if (too_small) begin
					mx_q <= mx_q << 1;
					my_q <= my_q << 1;
				end
			end
			N_SQ1: acc_q <= sq;
			N_SQ2: begin
				x_q   <= {1'b0, 51'(acc_q) + 51'(sq), 12'b0};
				r_q   <= '0;
				bit_q <= 64'd1 << 62;
				cnt_q <= 5'd31;
			end
			N_SQRT: begin
				if (ge) begin
					x_q <= diff[63:0];
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (last_iter) begin
					cnt_q <= 5'(QB - 1);
					len_q <= ge ? 32'((r_q >> 1) + bit_q) : 32'(r_q >> 1);
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
			// first division (my over len) is loaded in N_LOAD, once the root has settled
			N_LOAD: begin
				rem_q <= 32'(dvd_next_hi(my_q[NORM_W-1:0], len_q));
				dsh_q <= dvd_next_lo(my_q[NORM_W-1:0], len_q);
			end
			N_DIV1, N_DIV2: begin
				if (!last_iter) begin
					rem_q <= ge ? diff[31:0] : {rem_q[30:0], dsh_q[QB-1]};
					dsh_q <= {dsh_q[QB-2:0], ge};
					cnt_q <= cnt_q - 5'd1;
				end else if (state_q == N_DIV1) begin
					nx    <= sat({dsh_q[QB-2:0], ge}, dy_neg_q);
					// load the dividend for the next division
					rem_q <= 32'(dvd_next_hi(mx_q[NORM_W-1:0], len_q));
					dsh_q <= dvd_next_lo(mx_q[NORM_W-1:0], len_q);
					cnt_q <= 5'(QB - 1);
				end else begin
					ny <= sat({dsh_q[QB-2:0], ge}, dx_pos_q);
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/extrusion_wall_quad_generator_top.sv =====
// Top level of the extrusion wall quad generator: ring tracking, record
// sequencer and output register. Depends on ewq_pkg and ewq_normal_unit.
`timescale 1ns / 1ps
`default_nettype none
// Sequence: an edge holds the normal unit for its normalizing shifts s (0 to 24), squares,
// root and two divisions; ten records follow, each one stalled by out_ready. A closing
// point runs its edge from the previous point and then its edge back to the first point, where both are non-zero.
// in_ready is high only in idle, so no new point is taken while a point's edges are in
// the normal unit or its records are still being emitted.
// Reset: asynchronous, active low; clears ring state, counters and registers (walls_enable set).
module extrusion_wall_quad_generator_top #(
	parameter int COORD_WIDTH  = 24,
	parameter int NORMAL_WIDTH = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire signed [COORD_WIDTH-1:0] point_x,
	input  wire signed [COORD_WIDTH-1:0] point_y,
	input  wire                          ring_last,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic                         record_kind,
	output logic signed [COORD_WIDTH-1:0] pos_x,
	output logic signed [COORD_WIDTH-1:0] pos_y,
	output logic signed [COORD_WIDTH-1:0] pos_z,
	output logic signed [NORMAL_WIDTH-1:0] normal_x,
	output logic signed [NORMAL_WIDTH-1:0] normal_y,
	output logic                         tex_u,
	output logic                         tex_v,
	output logic [31:0]                  index_value,
	output logic                         last_record,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [1:0]                   cfg_index,
	input  wire  [31:0]                  cfg_data
);
	import ewq_pkg::*;

	localparam logic [32:0] ZMAX = (33'd1 << (COORD_WIDTH - 1)) - 33'd1;

	ctl_state_t state_q, state_d;
	logic [22:0] half_depth_q;
	logic [31:0] start_vertex_q, vcount_q;
	logic        walls_enable_q;
	logic [COORD_WIDTH-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [COORD_WIDTH-1:0] ea_x_q, ea_y_q, eb_x_q, eb_y_q;
	logic [1:0]  rps_q;
	logic        pend2_q, start_q;
	logic [3:0]  rec_q;

	logic        accept, gen_on, e1_nz, e2_nz, go, slot_free, emit, rec_done;
	logic        n_done;
	logic [NORMAL_WIDTH-1:0] n_x, n_y;
	logic [32:0] hz;
	logic [COORD_WIDTH-1:0] zp, zn;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign gen_on    = walls_enable_q && (half_depth_q != '0) && (start_vertex_q != '0);
	assign e1_nz     = (point_x != prev_x_q) || (point_y != prev_y_q);
	assign e2_nz     = ring_last && ((point_x != first_x_q) || (point_y != first_y_q));
	assign go        = accept && gen_on && (rps_q != 2'd0) && (e1_nz || e2_nz);
	assign slot_free = !out_valid || out_ready;
	assign emit      = (state_q == S_EMIT) && slot_free;
	assign rec_done  = emit && (rec_q == 4'(RECS_PER_QUAD - 1));

	assign hz = ({10'b0, half_depth_q} > ZMAX) ? ZMAX : {10'b0, half_depth_q};
	assign zp = hz[COORD_WIDTH-1:0];
	assign zn = COORD_WIDTH'(0) - zp;

	ewq_normal_unit #(
		.COORD_WIDTH (COORD_WIDTH),
		.NORMAL_WIDTH(NORMAL_WIDTH)
	) u_norm (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start_q),
		.ax    (ea_x_q),
		.ay    (ea_y_q),
		.bx    (eb_x_q),
		.by    (eb_y_q),
		.done  (n_done),
		.nx    (n_x),
		.ny    (n_y)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (go) state_d = S_NORM;
			S_NORM: if (n_done) state_d = S_EMIT;
			S_EMIT: if (rec_done) state_d = pend2_q ? S_NORM : S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			half_depth_q   <= '0;
			start_vertex_q <= '0;
			walls_enable_q <= 1'b1;
			vcount_q       <= '0;
			first_x_q      <= '0;
			first_y_q      <= '0;
			prev_x_q       <= '0;
			prev_y_q       <= '0;
			rps_q          <= 2'd0;
			pend2_q        <= 1'b0;
			start_q        <= 1'b0;
			rec_q          <= '0;
			out_valid      <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= go || (rec_done && pend2_q);
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_HALF_DEPTH:   half_depth_q <= cfg_data[22:0];
					REG_START_VERTEX: start_vertex_q <= cfg_data;
					REG_WALLS_ENABLE: walls_enable_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cfg_valid && cfg_index == REG_START_VERTEX) begin
				vcount_q <= '0;
			end else if (rec_done) begin
				vcount_q <= vcount_q + 32'd4;
			end
			if (accept && gen_on) begin
				prev_x_q <= point_x;
				prev_y_q <= point_y;
				if (rps_q == 2'd0) begin
					first_x_q <= point_x;
					first_y_q <= point_y;
					rps_q     <= ring_last ? 2'd0 : 2'd1;
				end else begin
					rps_q   <= ring_last ? 2'd0 : 2'd2;
					pend2_q <= e1_nz && e2_nz;
				end
			end
			if (emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (rec_done) begin
				rec_q   <= '0;
				pend2_q <= 1'b0;
			end else if (emit) begin
				rec_q <= rec_q + 4'd1;
			end
		end
	end

	// edge endpoints and output word
	always_ff @(posedge clk) begin
		if (go) begin
			if (e1_nz) begin
				ea_x_q <= prev_x_q;
				ea_y_q <= prev_y_q;
				eb_x_q <= point_x;
				eb_y_q <= point_y;
			end else begin
				ea_x_q <= point_x;
				ea_y_q <= point_y;
				eb_x_q <= first_x_q;
				eb_y_q <= first_y_q;
			end
		end
		if (rec_done && pend2_q) begin
			// closing edge: current point back to the ring's first point
			ea_x_q <= eb_x_q;
			ea_y_q <= eb_y_q;
			eb_x_q <= first_x_q;
			eb_y_q <= first_y_q;
		end
		if (emit) begin
			last_record <= (rec_q == 4'(RECS_PER_QUAD - 1)) && !pend2_q;
			if (rec_q < 4'd4) begin
				record_kind <= REC_VERTEX;
				pos_x       <= (rec_q == 4'd1 || rec_q == 4'd2) ? eb_x_q : ea_x_q;
				pos_y       <= (rec_q == 4'd1 || rec_q == 4'd2) ? eb_y_q : ea_y_q;
				pos_z       <= (rec_q < 4'd2) ? zp : zn;
				normal_x    <= n_x;
				normal_y    <= n_y;
				tex_u       <= (rec_q == 4'd1 || rec_q == 4'd2);
				tex_v       <= (rec_q >= 4'd2);
				index_value <= '0;
			end else begin
				record_kind <= REC_INDEX;
				pos_x       <= '0;
				pos_y       <= '0;
				pos_z       <= '0;
				normal_x    <= '0;
				normal_y    <= '0;
				tex_u       <= 1'b0;
				tex_v       <= 1'b0;
				index_value <= start_vertex_q + vcount_q + 32'(idx_offset(rec_q));
			end
		end
	end

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for extrusion_wall_quad_generator_top: ring points in,
// wall quad vertex and index records out. Depends on ewq_pkg and the RTL.
`timescale 1ns / 1ps
module tb_top;
	import ewq_pkg::*;

	localparam int CW = 24;
	localparam int NW = 16;
	localparam int DRAIN_CYCLES = 400;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 360;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic last;
	} ring_point_t;

	typedef struct {
		logic kind;
		logic [CW-1:0] px, py, pz;
		logic [NW-1:0] nx, ny;
		logic u, v;
		logic [31:0] idx;
		logic last;
	} wall_rec_t;

	logic clk, arst_n;
	logic in_valid, in_ready, ring_last;
	logic signed [CW-1:0] point_x, point_y;
	logic out_valid, out_ready;
	logic record_kind, tex_u, tex_v, last_record;
	logic signed [CW-1:0] pos_x, pos_y, pos_z;
	logic signed [NW-1:0] normal_x, normal_y;
	logic [31:0] index_value;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	extrusion_wall_quad_generator_top #(.COORD_WIDTH(CW), .NORMAL_WIDTH(NW)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y), .ring_last(ring_last),
		.out_valid(out_valid), .out_ready(out_ready),
		.record_kind(record_kind), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.normal_x(normal_x), .normal_y(normal_y), .tex_u(tex_u), .tex_v(tex_v),
		.index_value(index_value), .last_record(last_record),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ring_point_t pending_points[$];
	wall_rec_t expected_recs[$];
	wall_rec_t step_recs[$];
	int errors = 0;
	int cycles = 0;
	bit no_gaps = 0;

	// predictor copy of registers and ring state
	logic [22:0] half_depth_m;
	logic [31:0] start_vertex_m;
	logic walls_enable_m;
	longint first_x, first_y, prev_x, prev_y;
	int points_seen;
	logic [31:0] vertex_total;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned val);
		longint unsigned root = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > val) b >>= 2;
		while (b != 0) begin
			if (val >= root + b) begin
				val -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic logic [NW-1:0] unit_component(longint unsigned mag, bit neg,
			longint unsigned len);
		longint unsigned q;
		longint unsigned maxpos = (64'd1 << (NW - 1)) - 1;
		q = ((mag << (NW - 1 + 6)) + (len >> 1)) / len;
		if (neg) begin
			if (q > maxpos + 1) q = maxpos + 1;
			return NW'(64'd0 - q);
		end
		if (q > maxpos) q = maxpos;
		return NW'(q);
	endfunction

	function automatic wall_rec_t make_rec(logic kind, longint px, longint py,
			logic [CW-1:0] pz, logic [NW-1:0] nx, logic [NW-1:0] ny,
			logic u, logic v, logic [31:0] idx);
		wall_rec_t r;
		r.kind = kind;
		r.px = CW'(px);
		r.py = CW'(py);
		r.pz = pz;
		r.nx = nx;
		r.ny = ny;
		r.u = u;
		r.v = v;
		r.idx = idx;
		r.last = 1'b0;
		return r;
	endfunction

	task automatic put_rec(wall_rec_t r);
		step_recs = {step_recs, r};
	endtask

	task automatic wall_quad(longint ax, longint ay, longint bx, longint by);
		longint dx, dy;
		longint unsigned mx, my, big, len;
		logic [NW-1:0] nx, ny;
		logic [CW-1:0] zp, zn;
		logic [31:0] s;
		dx = bx - ax;
		dy = by - ay;
		if (dx == 0 && dy == 0) return;
		mx = dx < 0 ? -dx : dx;
		my = dy < 0 ? -dy : dy;
		big = mx > my ? mx : my;
		while (big >= (64'd1 << 25)) begin
			mx >>= 1; my >>= 1; big >>= 1;
		end
		while (big < (64'd1 << 24)) begin
			mx <<= 1; my <<= 1; big <<= 1;
		end
		len = int_sqrt((mx * mx + my * my) << 12);
		nx = unit_component(my, dy < 0, len);
		ny = unit_component(mx, dx > 0, len);
		zp = CW'(half_depth_m);
		zn = CW'(-longint'(half_depth_m));
		s = start_vertex_m + vertex_total;
		put_rec(make_rec(REC_VERTEX, ax, ay, zp, nx, ny, 0, 0, 0));
		put_rec(make_rec(REC_VERTEX, bx, by, zp, nx, ny, 1, 0, 0));
		put_rec(make_rec(REC_VERTEX, bx, by, zn, nx, ny, 1, 1, 0));
		put_rec(make_rec(REC_VERTEX, ax, ay, zn, nx, ny, 0, 1, 0));
		put_rec(make_rec(REC_INDEX, 0, 0, 0, 0, 0, 0, 0, s));
		put_rec(make_rec(REC_INDEX, 0, 0, 0, 0, 0, 0, 0, s + 1));
		put_rec(make_rec(REC_INDEX, 0, 0, 0, 0, 0, 0, 0, s + 2));
		put_rec(make_rec(REC_INDEX, 0, 0, 0, 0, 0, 0, 0, s));
		put_rec(make_rec(REC_INDEX, 0, 0, 0, 0, 0, 0, 0, s + 2));
		put_rec(make_rec(REC_INDEX, 0, 0, 0, 0, 0, 0, 0, s + 3));
		vertex_total += 4;
	endtask

	task automatic predict_walls(ring_point_t p);
		longint x, y;
		if (!walls_enable_m || half_depth_m == 0 || start_vertex_m == 0) return;
		x = longint'(p.x);
		y = longint'(p.y);
		step_recs.delete();
		if (points_seen == 0) begin
			first_x = x;
			first_y = y;
			points_seen = p.last ? 0 : 1;
		end else begin
			wall_quad(prev_x, prev_y, x, y);
			points_seen = 2;
			if (p.last) begin
				wall_quad(x, y, first_x, first_y);
				points_seen = 0;
			end
		end
		prev_x = x;
		prev_y = y;
		if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last = 1'b1;
		expected_recs = {expected_recs, step_recs};
	endtask

	// point driver
	always @(posedge clk or negedge arst_n) begin
		ring_point_t p;
		if (!arst_n) begin
			in_valid <= 1'b0;
			point_x <= '0;
			point_y <= '0;
			ring_last <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				p.x = point_x;
				p.y = point_y;
				p.last = ring_last;
				predict_walls(p);
			end
			if (!in_valid || in_ready) begin
				if (pending_points.size() > 0 && (no_gaps || $urandom_range(99) >= 25)) begin
					p = pending_points.pop_front();
					point_x <= p.x;
					point_y <= p.y;
					ring_last <= p.last;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// record monitor
	always @(posedge clk or negedge arst_n) begin
		wall_rec_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_recs.size() == 0) begin
					$error("record with no expectation waiting");
					errors++;
				end else begin
					e = expected_recs.pop_front();
					if (record_kind !== e.kind) begin
						$error("record_kind expected %h got %h", e.kind, record_kind); errors++;
					end
					if (pos_x !== e.px) begin
						$error("pos_x expected %h got %h", e.px, pos_x); errors++;
					end
					if (pos_y !== e.py) begin
						$error("pos_y expected %h got %h", e.py, pos_y); errors++;
					end
					if (pos_z !== e.pz) begin
						$error("pos_z expected %h got %h", e.pz, pos_z); errors++;
					end
					if (normal_x !== e.nx) begin
						$error("normal_x expected %h got %h", e.nx, normal_x); errors++;
					end
					if (normal_y !== e.ny) begin
						$error("normal_y expected %h got %h", e.ny, normal_y); errors++;
					end
					if (tex_u !== e.u) begin
						$error("tex_u expected %h got %h", e.u, tex_u); errors++;
					end
					if (tex_v !== e.v) begin
						$error("tex_v expected %h got %h", e.v, tex_v); errors++;
					end
					if (index_value !== e.idx) begin
						$error("index_value expected %h got %h", e.idx, index_value); errors++;
					end
					if (last_record !== e.last) begin
						$error("last_record expected %h got %h", e.last, last_record); errors++;
					end
				end
			end
			out_ready <= no_gaps || $urandom_range(99) >= 25;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_HALF_DEPTH: half_depth_m = data[22:0];
			REG_START_VERTEX: begin
				start_vertex_m = data;
				vertex_total = 0;
			end
			REG_WALLS_ENABLE: walls_enable_m = data[0];
			default: ;
		endcase
	endtask

	task automatic setup(logic [31:0] hd, logic [31:0] sv, logic en);
		write_reg(REG_HALF_DEPTH, hd);
		write_reg(REG_START_VERTEX, sv);
		write_reg(REG_WALLS_ENABLE, {31'($urandom), en});
	endtask

	// hold until every point is in and every record out, then let the core settle
	task automatic drain();
		while (pending_points.size() > 0 || in_valid || expected_recs.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add_point(int x, int y, logic last);
		ring_point_t p;
		p.x = CW'(x);
		p.y = CW'(y);
		p.last = last;
		pending_points = {pending_points, p};
	endtask

	function automatic int pick_coord(int mode, int base);
		case ($urandom_range(9))
			0: return $urandom_range(1) ? -(1 << 23) : (1 << 23) - 1;
			1: return base + $urandom_range(2) - 1;
			default: ;
		endcase
		if (mode == 0) return $signed(CW'($urandom));
		return base + $signed(12'($urandom));
	endfunction

	task automatic random_ring(int n);
		int x, y, mode;
		mode = $urandom_range(1);
		x = $signed(CW'($urandom));
		y = $signed(CW'($urandom));
		for (int i = 0; i < n; i++) begin
			// repeat the previous point now and then to get zero-length edges
			if ($urandom_range(9) != 0) begin
				x = pick_coord(mode, x);
				y = pick_coord(mode, y);
			end
			add_point(x, y, i == n - 1);
		end
	endtask

	initial begin
		int sent, n;
		logic [31:0] hd, sv;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		half_depth_m = '0;
		start_vertex_m = '0;
		walls_enable_m = 1'b1;
		first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
		points_seen = 0;
		vertex_total = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// after reset the mesh is empty: points are dropped
		add_point(100, 200, 1'b0);
		add_point(300, 400, 1'b1);
		drain();

		setup(32'h0000_1000, 32'd1, 1'b1);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		add_point(0, 0, 1'b0);
		add_point(32'h1000, 0, 1'b0);
		add_point(0, 32'h1000, 1'b1);
		add_point(-(1 << 23), -(1 << 23), 1'b0);
		add_point((1 << 23) - 1, (1 << 23) - 1, 1'b1);
		add_point((1 << 23) - 1, -(1 << 23), 1'b0);
		add_point(-(1 << 23), (1 << 23) - 1, 1'b1);
		add_point(7, 7, 1'b1);
		add_point(5, 5, 1'b0);
		add_point(5, 5, 1'b0);
		add_point(6, 5, 1'b0);
		add_point(6, 4, 1'b1);
		add_point(1, 1, 1'b0);
		add_point(2, 2, 1'b0);
		add_point(1, 1, 1'b1);
		drain();

		// widest half depth, vertex numbers wrapping
		setup(32'hFFFF_FFFF, 32'hFFFF_FFFA, 1'b1);
		add_point(-1, 0, 1'b0);
		add_point(0, -1, 1'b0);
		add_point(3, 0, 1'b1);
		drain();

		setup(32'h0000_0800, 32'd64, 1'b0);
		add_point(10, 10, 1'b0);
		add_point(20, 30, 1'b1);
		drain();
		setup(32'd0, 32'd64, 1'b1);
		add_point(10, 10, 1'b1);
		drain();
		setup(32'd1, 32'd0, 1'b1);
		add_point(10, 10, 1'b1);
		drain();

		sent = 0;
		for (int ph = 0; sent < RANDOM_ITEMS; ph++) begin
			hd = $urandom_range(3) == 0 ? ($urandom_range(1) ? 32'd1 : 32'h7F_FFFF) : $urandom;
			sv = $urandom_range(3) == 0 ? 32'hFFFF_FFF0 | $urandom_range(15) : $urandom;
			if (hd[22:0] == 0) hd = 32'd1;
			if (sv == 0) sv = 32'd1;
			setup(hd, sv, 1'b1);
			no_gaps = (ph == 2);
			for (int k = 0; k < 60 && sent < RANDOM_ITEMS; k += n) begin
				n = $urandom_range(3) == 0 ? 1 : $urandom_range(6, 2);
				random_ring(n);
				sent += n;
			end
			drain();
			no_gaps = 0;
		end

		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule
